// File: src/ypl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypl_pkg: shared types and constants for the yaw/pitch look vector block
// Angle and vector formats, request and response word types, the command
// word held in the queue and the coefficients of the quarter-wave sine.
// ----------------------------------------------------------------------------
package ypl_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int VECTOR_BITS = 16;
  localparam int LIMIT_BITS  = 14;

  // Pitch difference is formed one bit wider than both operands.
  localparam int DIFF_BITS   = (ANGLE_BITS > 16) ? ANGLE_BITS + 1 : 17;

  localparam int VEC_ONE     = 2 ** (VECTOR_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(2 ** (ANGLE_BITS - 2));
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(15646);

  localparam int QUEUE_DEPTH = 4;
  localparam int SINE_STAGES = 6;

  // Quarter-wave polynomial coefficients, Q15 arithmetic.
  localparam logic [16:0] QS_HALF_TURN = 17'd32768;
  localparam logic [16:0] QS_C1 = 17'd51472;
  localparam logic [15:0] QS_C2 = 16'd21024;
  localparam logic [11:0] QS_C3 = 12'd2320;

  localparam logic REQ_ROTATE = 1'b0;
  localparam logic REQ_PLACE  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] yaw_value;
    logic signed [15:0] pitch_value;
  } req_t;

  typedef struct packed {
    logic signed [15:0] look_x;
    logic signed [15:0] look_y;
    logic signed [15:0] look_z;
    logic        [15:0] yaw_now;
    logic signed [15:0] pitch_now;
  } rsp_t;

  typedef struct packed {
    logic                         req_type;
    logic        [ANGLE_BITS-1:0] yaw;
    logic signed [ANGLE_BITS-1:0] pitch;
  } cmd_t;

endpackage

// File: src/yaw_pitch_look_vector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_pitch_look_vector: camera yaw/pitch tracker with look vector output
// Keeps yaw and pitch as binary angles and returns a Q1.14 unit look vector.
// ----------------------------------------------------------------------------
// Usage:
// Request words (in_valid/in_ready) either rotate by deltas or place absolute
// angles. Every request yields exactly one response word (out_valid/
// out_ready) carrying the look vector and the angles after that request.
// The cfg channel writes the pitch limit; it is always ready and should be
// written only while no request is in flight.
// From acceptance a word passes the command queue, the sine pipeline, the
// product register and the output register. Throughput is one word per
// cycle while the receiver takes words and the queue has room.
// When the receiver stalls, the output register holds its word and the back
// pipeline freezes; the 4-entry command queue keeps accepting until full.
// Reset clears the angles, points the vector at negative z, restores the
// default limit (about 1.5 rad) and empties queue and pipeline.
// ----------------------------------------------------------------------------
module yaw_pitch_look_vector #(
  parameter int QUEUE_DEPTH = ypl_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ypl_pkg::req_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ypl_pkg::rsp_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ypl_pkg::LIMIT_BITS-1:0] cfg_data
);

  logic          q_full;
  logic          q_push;
  ypl_pkg::cmd_t q_wdata;
  logic          q_pop;
  logic          q_valid;
  ypl_pkg::cmd_t q_rdata;

  ypl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  ypl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_push  (q_push),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd_pop   (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rdata)
  );

  ypl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: src/ypl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypl_front: angle tracker
// Accepts request words, updates yaw and pitch, clamps pitch on
// rotate and pushes the resulting angles into the command queue.
// ----------------------------------------------------------------------------
module ypl_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ypl_pkg::req_t                       in_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ypl_pkg::LIMIT_BITS-1:0]      cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output ypl_pkg::cmd_t                       q_data
);

  localparam int AB = ypl_pkg::ANGLE_BITS;
  localparam int DB = ypl_pkg::DIFF_BITS;
  localparam logic signed [DB-1:0] CAP = DB'((2 ** (AB - 1)) - 1);

  logic [ypl_pkg::LIMIT_BITS-1:0] pitch_limit;
  logic [AB-1:0]                  yaw_angle;
  logic signed [AB-1:0]           pitch_angle;
  logic [AB-1:0]                  yaw_next;
  logic signed [AB-1:0]           pitch_next;
  logic signed [DB-1:0]           diff;
  logic signed [DB-1:0]           lim_raw;
  logic signed [DB-1:0]           lim;
  logic signed [DB-1:0]           neg_lim;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;

  always_comb begin
    diff    = DB'(pitch_angle) - DB'(in_data.pitch_value);
    lim_raw = DB'(signed'({1'b0, pitch_limit}));
    lim     = (lim_raw > CAP) ? CAP : lim_raw;
    neg_lim = -lim;
    if (in_data.req_type == ypl_pkg::REQ_PLACE) begin
      yaw_next   = AB'(in_data.yaw_value);
      pitch_next = AB'(in_data.pitch_value);
    end else begin
      yaw_next = yaw_angle + AB'(in_data.yaw_value);
      priority if (diff > lim) begin
        pitch_next = AB'(lim);
      end else if (diff < neg_lim) begin
        pitch_next = AB'(neg_lim);
      end else begin
        pitch_next = AB'(diff);
      end
    end
    q_data.req_type = in_data.req_type;
    q_data.yaw      = yaw_next;
    q_data.pitch    = pitch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_limit <= ypl_pkg::LIMIT_RESET;
      yaw_angle   <= '0;
      pitch_angle <= '0;
    end else begin
      if (cfg_valid) begin
        pitch_limit <= cfg_data;
      end
      if (q_push) begin
        yaw_angle   <= yaw_next;
        pitch_angle <= pitch_next;
      end
    end
  end

endmodule

// File: src/ypl_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypl_fifo: command queue
// Small register queue between the angle tracker and the vector pipeline.
// ----------------------------------------------------------------------------
module ypl_fifo #(
  parameter int DEPTH = ypl_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_push,
  input  ypl_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_pop,
  output logic          rd_valid,
  output ypl_pkg::cmd_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ypl_pkg::cmd_t  mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_push  = wr_push && !full;
  assign do_pop   = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/ypl_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypl_sine: pipelined fixed-point sine
// Quarter-wave polynomial over six register stages, at most one multiply per stage.
// ----------------------------------------------------------------------------
module ypl_sine (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic        [ypl_pkg::ANGLE_BITS-1:0]      angle,
  output logic signed [ypl_pkg::VECTOR_BITS-1:0]     sine
);

  localparam int AB = ypl_pkg::ANGLE_BITS;
  localparam int VB = ypl_pkg::VECTOR_BITS;
  localparam int FW = AB - 2 + 15;
  localparam int MW = 16 + VB - 1;

  logic [FW-1:0] frac_wide;
  logic [15:0]   u_raw;
  logic [15:0]   u_mir;
  logic [27:0]   t_prod;
  logic [30:0]   s_prod;
  logic [MW-1:0] mag_wide;
  logic [VB-2:0] mag;

  logic [15:0] s1_u;
  logic        s1_neg;
  logic [15:0] s2_u;
  logic [15:0] s2_u2;
  logic        s2_neg;
  logic [15:0] s3_u;
  logic [15:0] s3_u2;
  logic [14:0] s3_t;
  logic        s3_neg;
  logic [15:0] s4_u;
  logic [15:0] s4_s;
  logic        s4_neg;
  logic [15:0] s5_s15;
  logic        s5_neg;

  always_comb begin
    frac_wide = {angle[AB-3:0], 15'd0};
    u_raw     = 16'(frac_wide >> (AB - 2));
    // Odd quadrants run the quarter wave backward.
    u_mir     = angle[AB-2] ? 16'(ypl_pkg::QS_HALF_TURN - 17'(u_raw)) : u_raw;
    t_prod    = 28'(s2_u2) * 28'(ypl_pkg::QS_C3);
    s_prod    = 31'(s3_u2) * 31'(s3_t);
    mag_wide  = MW'(s5_s15) * MW'(ypl_pkg::VEC_ONE) + MW'(16384);
    mag       = (VB - 1)'(mag_wide >> 15);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_u   <= u_mir;
      s1_neg <= angle[AB-1];

      s2_u   <= s1_u;
      s2_u2  <= 16'((32'(s1_u) * 32'(s1_u)) >> 15);
      s2_neg <= s1_neg;

      s3_u   <= s2_u;
      s3_u2  <= s2_u2;
      s3_t   <= 15'(ypl_pkg::QS_C2 - 16'(t_prod >> 15));
      s3_neg <= s2_neg;

      s4_u   <= s3_u;
      s4_s   <= 16'(ypl_pkg::QS_C1 - 17'(s_prod >> 15));
      s4_neg <= s3_neg;

      s5_s15 <= 16'((32'(s4_u) * 32'(s4_s)) >> 15);
      s5_neg <= s4_neg;

      sine   <= s5_neg ? -VB'(mag) : VB'(mag);
    end
  end

endmodule

// File: src/ypl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypl_back: look vector pipeline
// Pops commands, evaluates the four sines, forms the rounded products and
// holds the result word in the output register. Place commands pass the
// last computed vector through.
// ----------------------------------------------------------------------------
module ypl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  ypl_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output ypl_pkg::rsp_t out_data
);

  localparam int VB = ypl_pkg::VECTOR_BITS;
  localparam int NS = ypl_pkg::SINE_STAGES;
  localparam int PW = 2 * VB - 2;
  localparam logic [PW-1:0] HALF = PW'(ypl_pkg::VEC_ONE / 2);

  logic adv;

  logic          pipe_valid [NS];
  ypl_pkg::cmd_t pipe_cmd   [NS];

  logic signed [VB-1:0] sin_yaw;
  logic signed [VB-1:0] cos_yaw;
  logic signed [VB-1:0] sin_pitch;
  logic signed [VB-1:0] cos_pitch;

  logic [VB-2:0] abs_sy;
  logic [VB-2:0] abs_cy;
  logic [VB-2:0] abs_cp;

  logic                 m_valid;
  ypl_pkg::cmd_t        m_cmd;
  logic [PW-1:0]        m_prod_x;
  logic [PW-1:0]        m_prod_z;
  logic                 m_neg_x;
  logic                 m_neg_z;
  logic signed [VB-1:0] m_y;

  logic [VB-2:0]        rnd_x;
  logic [VB-2:0]        rnd_z;
  logic signed [VB-1:0] val_x;
  logic signed [VB-1:0] val_z;

  logic signed [VB-1:0] vec_x;
  logic signed [VB-1:0] vec_y;
  logic signed [VB-1:0] vec_z;

  // The whole pipeline moves together whenever the output register frees up.
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  ypl_sine u_sin_yaw (
    .clk   (clk),
    .en    (adv),
    .angle (q_data.yaw),
    .sine  (sin_yaw)
  );

  ypl_sine u_cos_yaw (
    .clk   (clk),
    .en    (adv),
    .angle (q_data.yaw + ypl_pkg::QUARTER),
    .sine  (cos_yaw)
  );

  ypl_sine u_sin_pitch (
    .clk   (clk),
    .en    (adv),
    .angle (q_data.pitch),
    .sine  (sin_pitch)
  );

  ypl_sine u_cos_pitch (
    .clk   (clk),
    .en    (adv),
    .angle (q_data.pitch + ypl_pkg::QUARTER),
    .sine  (cos_pitch)
  );

  always_comb begin
    abs_sy = (VB - 1)'(sin_yaw[VB-1] ? -sin_yaw : sin_yaw);
    abs_cy = (VB - 1)'(cos_yaw[VB-1] ? -cos_yaw : cos_yaw);
    abs_cp = (VB - 1)'(cos_pitch[VB-1] ? -cos_pitch : cos_pitch);
    rnd_x  = (VB - 1)'((m_prod_x + HALF) >> (VB - 2));
    rnd_z  = (VB - 1)'((m_prod_z + HALF) >> (VB - 2));
    val_x  = m_neg_x ? -VB'(rnd_x) : VB'(rnd_x);
    val_z  = m_neg_z ? -VB'(rnd_z) : VB'(rnd_z);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_cmd[0] <= q_data;
      for (int i = 1; i < NS; i++) begin
        pipe_cmd[i] <= pipe_cmd[i-1];
      end
      m_cmd    <= pipe_cmd[NS-1];
      m_prod_x <= PW'(abs_sy) * PW'(abs_cp);
      m_prod_z <= PW'(abs_cy) * PW'(abs_cp);
      m_neg_x  <= sin_yaw[VB-1] != cos_pitch[VB-1];
      // z carries an extra negation.
      m_neg_z  <= cos_yaw[VB-1] == cos_pitch[VB-1];
      m_y      <= sin_pitch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        pipe_valid[i] <= 1'b0;
      end
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
      vec_x     <= '0;
      vec_y     <= '0;
      vec_z     <= -VB'(ypl_pkg::VEC_ONE);
    end else if (adv) begin
      pipe_valid[0] <= q_valid;
      for (int i = 1; i < NS; i++) begin
        pipe_valid[i] <= pipe_valid[i-1];
      end
      m_valid   <= pipe_valid[NS-1];
      out_valid <= m_valid;
      if (m_valid && m_cmd.req_type == ypl_pkg::REQ_ROTATE) begin
        vec_x <= val_x;
        vec_y <= m_y;
        vec_z <= val_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && m_valid) begin
      if (m_cmd.req_type == ypl_pkg::REQ_ROTATE) begin
        out_data.look_x <= 16'(val_x);
        out_data.look_y <= 16'(m_y);
        out_data.look_z <= 16'(val_z);
      end else begin
        out_data.look_x <= 16'(vec_x);
        out_data.look_y <= 16'(vec_y);
        out_data.look_z <= 16'(vec_z);
      end
      out_data.yaw_now   <= 16'(m_cmd.yaw);
      out_data.pitch_now <= 16'(m_cmd.pitch);
    end
  end

endmodule

// File: src/ypl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypl_checker: port-level checks for yaw_pitch_look_vector
// Watches the top-level ports only and is attached by a bind statement.
// ----------------------------------------------------------------------------
module ypl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input ypl_pkg::req_t                  in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input ypl_pkg::rsp_t                  out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [ypl_pkg::LIMIT_BITS-1:0] cfg_data
);

  // A stalled response word must stay put.
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response word changed while stalled");

  // A waiting request word holds still until it is taken.
  a_in_hold : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request word changed while waiting");

  // The limit register takes a known word whenever one is offered.
  a_cfg_ready : assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready && !$isunknown(cfg_data))
    else $error("limit word refused or unknown");

  // Right after reset nothing is pending and the queue has room.
  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("block not empty after reset");

  // Every component of the look vector stays within one unit.
  a_vec_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      out_data.look_x <= ypl_pkg::VEC_ONE && out_data.look_x >= -ypl_pkg::VEC_ONE &&
      out_data.look_y <= ypl_pkg::VEC_ONE && out_data.look_y >= -ypl_pkg::VEC_ONE &&
      out_data.look_z <= ypl_pkg::VEC_ONE && out_data.look_z >= -ypl_pkg::VEC_ONE)
    else $error("look vector component out of range");

endmodule

bind yaw_pitch_look_vector ypl_checker u_ypl_checker (.*);
